// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl file dennt_dp.sv
// no dependencies; NO_ASSERTIONS turns every use into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
		else $error("invariant violated");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check violated");

`else

`define ASSERT_ALWAYS(lbl, ck, rn, cond)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== rtl/dennt_pkg.sv =====
// constants, types and controller codes of the double-ended tour builder
// no dependencies
`default_nettype none

package dennt_pkg;

	localparam int MAX_CITIES    = 64;
	localparam int DIST_BITS     = 16;

	// fixed port widths
	localparam int ROW_BITS      = 6;
	localparam int DIST_IN_BITS  = 16;
	localparam int CITY_OUT_BITS = 7;
	localparam int CFG_BITS      = 7;
	localparam int CFG_RESET     = 64;

	localparam int CITY_BITS  = $clog2(MAX_CITIES);
	localparam int CNT_BITS   = $clog2(MAX_CITIES + 1);
	localparam int TOUR_DEPTH = 2 * MAX_CITIES;
	localparam int SLOT_BITS  = $clog2(TOUR_DEPTH);
	localparam int DADDR_BITS = 2 * CITY_BITS;
	localparam int DIST_DEPTH = 1 << DADDR_BITS;

	typedef logic [DIST_BITS-1:0] dist_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_EMIT_OUT
	} state_t;

	typedef struct packed {
		logic load_write;
		logic start;
		logic init_write;
		logic scan_clear;
		logic scan_issue;
		logic place;
		logic emit_load;
		logic emit_next;
	} dp_cmd_t;

	typedef struct packed {
		logic one_city;
		logic scan_last;
		logic place_last;
		logic emit_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/dennt_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dennt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/dennt_ctrl.sv =====
// sequencer of the tour builder: load, scan, place and emit phases
// depends on dennt_pkg
`default_nettype none

module dennt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  final_entry,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  dennt_pkg::dp_status_t status,
	output dennt_pkg::dp_cmd_t    cmd
);

	import dennt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && final_entry) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = status.one_city ? ST_EMIT_RD : ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				state_d = status.place_last ? ST_EMIT_RD : ST_SCAN;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_ready) begin
					state_d = status.emit_last ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready       = 1'b1;
				cmd.load_write = in_valid;
				cmd.start      = in_valid && final_entry;
			end
			ST_INIT: begin
				cmd.init_write = 1'b1;
				cmd.scan_clear = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_PLACE: begin
				cmd.place      = 1'b1;
				cmd.scan_clear = 1'b1;
			end
			ST_EMIT_RD: begin
			end
			ST_EMIT_WAIT: begin
				cmd.emit_load = 1'b1;
			end
			ST_EMIT_OUT: begin
				out_valid     = 1'b1;
				cmd.emit_next = out_ready;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dennt_dp.sv =====
// datapath: distance and tour memories, visited map, scan and compare, output word
// depends on dennt_pkg, dennt_ram and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dennt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dennt_pkg::dp_cmd_t                   cmd,
	output dennt_pkg::dp_status_t                status,
	input  logic [dennt_pkg::ROW_BITS-1:0]       row,
	input  logic [dennt_pkg::ROW_BITS-1:0]       col,
	input  logic [dennt_pkg::DIST_IN_BITS-1:0]   distance,
	input  logic                                 cfg_we,
	input  logic [dennt_pkg::CFG_BITS-1:0]       cfg_wdata,
	output logic [dennt_pkg::CITY_OUT_BITS-1:0]  city,
	output logic                                 tour_end
);

	import dennt_pkg::*;

	logic [CFG_BITS-1:0]      city_count_q;
	logic [CNT_BITS-1:0]      n_q;
	logic [CNT_BITS-1:0]      n_next;
	logic [CNT_BITS-1:0]      placed_q;
	logic [CITY_BITS-1:0]     front_city_q;
	logic [CITY_BITS-1:0]     back_city_q;
	logic [SLOT_BITS-1:0]     front_slot_q;
	logic [SLOT_BITS-1:0]     back_slot_q;
	logic [MAX_CITIES-1:0]    visited_q;

	logic [CITY_BITS-1:0]     i_q;
	logic                     side_q;
	logic                     vld_s1;
	logic [CITY_BITS-1:0]     i_s1;
	logic                     side_s1;
	logic                     i_last;
	logic [CITY_BITS-1:0]     from_s0;
	logic [CITY_BITS-1:0]     from_s1;
	logic                     cand;
	logic                     upd_f;
	logic                     upd_b;

	logic                     found_f_q;
	logic                     found_b_q;
	dist_t                    best_fd_q;
	dist_t                    best_bd_q;
	logic [CITY_BITS-1:0]     best_fc_q;
	logic [CITY_BITS-1:0]     best_bc_q;
	logic                     front_pick;
	logic [CITY_BITS-1:0]     pick_city;
	logic [SLOT_BITS-1:0]     pick_slot;

	logic [CITY_BITS-1:0]     k_q;
	logic [CITY_OUT_BITS-1:0] city_q;
	logic                     tour_end_q;

	logic                     row_ok;
	logic                     dist_we;
	logic [DADDR_BITS-1:0]    dist_waddr;
	logic [DADDR_BITS-1:0]    dist_raddr;
	dist_t                    dist_wdata;
	dist_t                    dist_rdata;

	logic                     tour_we;
	logic [SLOT_BITS-1:0]     tour_waddr;
	logic [SLOT_BITS-1:0]     tour_raddr;
	logic [CITY_BITS-1:0]     tour_wdata;
	logic [CITY_BITS-1:0]     tour_rdata;

	// matrix load
	assign row_ok = ({1'b0, row} < 7'(MAX_CITIES)) && ({1'b0, col} < 7'(MAX_CITIES));
	assign dist_we    = cmd.load_write && row_ok;
	assign dist_waddr = {row[CITY_BITS-1:0], col[CITY_BITS-1:0]};
	assign dist_wdata = DIST_BITS'(distance);

	// city count of zero runs as one, above the maximum saturates
	always_comb begin
		if (city_count_q == '0) begin
			n_next = CNT_BITS'(1);
		end else if (city_count_q > CFG_BITS'(MAX_CITIES)) begin
			n_next = CNT_BITS'(MAX_CITIES);
		end else begin
			n_next = CNT_BITS'(city_count_q);
		end
	end

	// scan: front row first, then back row, one entry a cycle
	assign i_last     = (CNT_BITS'(i_q) == n_q - CNT_BITS'(1));
	assign from_s0    = side_q ? back_city_q : front_city_q;
	assign dist_raddr = {from_s0, i_q};
	assign from_s1    = side_s1 ? back_city_q : front_city_q;
	assign cand       = vld_s1 && (i_s1 != from_s1) && !visited_q[i_s1];
	// strict less keeps the lowest index on ties
	assign upd_f = cand && !side_s1 && (!found_f_q || dist_rdata < best_fd_q);
	assign upd_b = cand && side_s1 && (!found_b_q || dist_rdata < best_bd_q);

	assign front_pick = (best_fd_q <= best_bd_q);
	assign pick_city  = front_pick ? best_fc_q : best_bc_q;
	assign pick_slot  = front_pick ? front_slot_q - SLOT_BITS'(1)
	                               : back_slot_q + SLOT_BITS'(1);

	assign tour_we    = cmd.init_write || cmd.place;
	assign tour_waddr = cmd.place ? pick_slot : SLOT_BITS'(MAX_CITIES);
	assign tour_wdata = cmd.place ? pick_city : '0;
	assign tour_raddr = front_slot_q + SLOT_BITS'(k_q);

	assign status.one_city   = (n_q == CNT_BITS'(1));
	assign status.scan_last  = side_q && i_last;
	assign status.place_last = (placed_q + CNT_BITS'(1) == n_q);
	assign status.emit_last  = (CNT_BITS'(k_q) == n_q - CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CFG_BITS'(CFG_RESET);
			n_q          <= CNT_BITS'(1);
			placed_q     <= '0;
			front_city_q <= '0;
			back_city_q  <= '0;
			front_slot_q <= '0;
			back_slot_q  <= '0;
			visited_q    <= '0;
			i_q          <= '0;
			side_q       <= 1'b0;
			vld_s1       <= 1'b0;
			found_f_q    <= 1'b0;
			found_b_q    <= 1'b0;
			k_q          <= '0;
		end else begin
			if (cfg_we) begin
				city_count_q <= cfg_wdata;
			end
			if (cmd.start) begin
				n_q          <= n_next;
				placed_q     <= CNT_BITS'(1);
				front_city_q <= '0;
				back_city_q  <= '0;
				front_slot_q <= SLOT_BITS'(MAX_CITIES);
				back_slot_q  <= SLOT_BITS'(MAX_CITIES);
				visited_q    <= MAX_CITIES'(1);
				k_q          <= '0;
			end
			if (cmd.place) begin
				placed_q             <= placed_q + CNT_BITS'(1);
				visited_q[pick_city] <= 1'b1;
				if (front_pick) begin
					front_slot_q <= pick_slot;
					front_city_q <= pick_city;
				end else begin
					back_slot_q <= pick_slot;
					back_city_q <= pick_city;
				end
			end
			vld_s1 <= cmd.scan_issue;
			if (cmd.scan_clear) begin
				i_q       <= '0;
				side_q    <= 1'b0;
				found_f_q <= 1'b0;
				found_b_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					if (i_last) begin
						i_q    <= '0;
						side_q <= 1'b1;
					end else begin
						i_q <= i_q + CITY_BITS'(1);
					end
				end
				if (upd_f) begin
					found_f_q <= 1'b1;
				end
				if (upd_b) begin
					found_b_q <= 1'b1;
				end
			end
			if (cmd.emit_next) begin
				k_q <= k_q + CITY_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1    <= i_q;
		side_s1 <= side_q;
		if (upd_f) begin
			best_fd_q <= dist_rdata;
			best_fc_q <= i_s1;
		end
		if (upd_b) begin
			best_bd_q <= dist_rdata;
			best_bc_q <= i_s1;
		end
		if (cmd.emit_load) begin
			city_q     <= CITY_OUT_BITS'(tour_rdata) + CITY_OUT_BITS'(1);
			tour_end_q <= status.emit_last;
		end
	end

	assign city     = city_q;
	assign tour_end = tour_end_q;

	dennt_ram #(
		.WIDTH (DIST_BITS),
		.DEPTH (DIST_DEPTH)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	dennt_ram #(
		.WIDTH (CITY_BITS),
		.DEPTH (TOUR_DEPTH)
	) u_tour_ram (
		.clk   (clk),
		.we    (tour_we),
		.waddr (tour_waddr),
		.wdata (tour_wdata),
		.raddr (tour_raddr),
		.rdata (tour_rdata)
	);

	`ASSERT_ALWAYS(a_place_found, clk, arst_n, !cmd.place || (found_f_q && found_b_q))
	`ASSERT_ALWAYS(a_place_unvisited, clk, arst_n, !cmd.place || !visited_q[pick_city])
	`ASSERT_ALWAYS(a_slot_order, clk, arst_n, front_slot_q <= back_slot_q)
	`ASSERT_NEXT(a_start_visited, clk, arst_n, cmd.start, visited_q == MAX_CITIES'(1))
	`ASSERT_NEXT(a_start_placed, clk, arst_n, cmd.start, placed_q == CNT_BITS'(1))

endmodule

`default_nettype wire

// ===== rtl/double_ended_nearest_neighbor_tour_core.sv =====
// Double-ended nearest-neighbor tour builder, top level.
// Input channel (in_valid/in_ready) carries matrix words: row, col, distance,
// final_entry. Words load at one per cycle into the distance memory.
// The word with final_entry set is stored, then starts tour construction;
// no input word is taken until the whole tour has been delivered.
// Construction: a setup state, then per placed city a scan of 2*N memory
// reads (front row, back row, single read port), a drain state for the
// last compare and a state for the placement.
// Output channel (out_valid/out_ready) then gives N words, city numbered
// from 1 with tour_end on the last; each word takes a tour memory read, the
// output register load and the handshake, and the next read waits for it.
// A stalled receiver holds the output word in its register; nothing is lost.
// cfg_we/cfg_wdata write city_count; write only while the block is loading.
// Reset (arst_n low) returns to loading with city_count at 64; the distance
// memory keeps whatever it held and is defined only where written.
// depends on dennt_pkg, dennt_ctrl, dennt_dp
`default_nettype none

module double_ended_nearest_neighbor_tour_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dennt_pkg::ROW_BITS-1:0]       row,
	input  logic [dennt_pkg::ROW_BITS-1:0]       col,
	input  logic [dennt_pkg::DIST_IN_BITS-1:0]   distance,
	input  logic                                 final_entry,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dennt_pkg::CITY_OUT_BITS-1:0]  city,
	output logic                                 tour_end,
	input  logic                                 cfg_we,
	input  logic [dennt_pkg::CFG_BITS-1:0]       cfg_wdata
);

	import dennt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dennt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.final_entry (final_entry),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	dennt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.row       (row),
		.col       (col),
		.distance  (distance),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.city      (city),
		.tour_end  (tour_end)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_double_ended_nearest_neighbor_tour_core.sv =====
`timescale 1ns / 100ps
// testbench of the double-ended nearest-neighbor tour builder: directed and random matrix
// words, each tour predicted in a scoreboard class and checked word by word on the output
// depends on dennt_pkg and double_ended_nearest_neighbor_tour_core
module tb_double_ended_nearest_neighbor_tour_core;
	import dennt_pkg::*;

	localparam int IDLE_LIMIT   = 40000;
	localparam int RANDOM_WORDS = 250;

	typedef enum {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

	typedef struct {
		logic [ROW_BITS-1:0] r;
		logic [ROW_BITS-1:0] c;
	} pair_t;

	class tour_scoreboard;
		typedef struct packed {
			logic [CITY_OUT_BITS-1:0] city;
			logic                     last;
		} stop_t;

		dist_t                dist_mem [DIST_DEPTH];
		bit                   visited [MAX_CITIES];
		logic [CITY_BITS-1:0] ring [TOUR_DEPTH];
		logic [CFG_BITS-1:0]  city_count;
		stop_t                stops_due [$];
		int                   mismatches;

		function new();
			city_count = CFG_BITS'(CFG_RESET);
			mismatches = 0;
			foreach (dist_mem[i])
				dist_mem[i] = '0;
		endfunction

		function void set_count(logic [CFG_BITS-1:0] v);
			city_count = v;
		endfunction

		function int pending();
			return stops_due.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// nearest unvisited city among the first n, first index kept on a tie
		function void closest(input int from, input int n, output int best, output dist_t best_d);
			bit found;
			found = 1'b0;
			best = 0;
			best_d = '0;
			for (int i = 0; i < n; i++) begin
				if (i == from || visited[i])
					continue;
				if (!found || dist_mem[from * MAX_CITIES + i] < best_d) begin
					found = 1'b1;
					best_d = dist_mem[from * MAX_CITIES + i];
					best = i;
				end
			end
		endfunction

		function void note_entry(logic [ROW_BITS-1:0] r, logic [ROW_BITS-1:0] c,
				logic [DIST_IN_BITS-1:0] d, logic f);
			int    n, fc, bc, front, back, head, tail, placed;
			dist_t fd, bd;
			stop_t s;
			dist_mem[{r, c}] = dist_t'(d);
			if (!f)
				return;
			n = int'(city_count);
			if (n < 1)
				n = 1;
			if (n > MAX_CITIES)
				n = MAX_CITIES;
			foreach (visited[i])
				visited[i] = 1'b0;
			front = 0;
			back = 0;
			head = MAX_CITIES;
			tail = MAX_CITIES;
			ring[MAX_CITIES] = '0;
			visited[0] = 1'b1;
			placed = 1;
			while (placed < n) begin
				closest(front, n, fc, fd);
				closest(back, n, bc, bd);
				// front end wins equal distances
				if (fd <= bd) begin
					head = (head + TOUR_DEPTH - 1) % TOUR_DEPTH;
					ring[head] = CITY_BITS'(fc);
					front = fc;
					visited[fc] = 1'b1;
				end else begin
					tail = (tail + 1) % TOUR_DEPTH;
					ring[tail] = CITY_BITS'(bc);
					back = bc;
					visited[bc] = 1'b1;
				end
				placed++;
			end
			for (int k = 0; k < n; k++) begin
				s.city = CITY_OUT_BITS'(ring[(head + k) % TOUR_DEPTH]) + 1'b1;
				s.last = (k == n - 1);
				stops_due.insert(stops_due.size(), s);
			end
		endfunction

		function void check_city(logic [CITY_OUT_BITS-1:0] got_city, logic got_end);
			stop_t want;
			if (stops_due.size() == 0) begin
				flag($sformatf("unexpected word city %0d tour_end %0b", got_city, got_end));
				return;
			end
			want = stops_due.pop_front();
			if (got_city !== want.city || got_end !== want.last)
				flag($sformatf("city %0d tour_end %0b, expected city %0d tour_end %0b",
					got_city, got_end, want.city, want.last));
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [ROW_BITS-1:0]      row;
	logic [ROW_BITS-1:0]      col;
	logic [DIST_IN_BITS-1:0]  distance;
	logic                     final_entry;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [CITY_OUT_BITS-1:0] city;
	logic                     tour_end;
	logic                     cfg_we;
	logic [CFG_BITS-1:0]      cfg_wdata;

	tour_scoreboard      sb;
	bit                  written [DIST_DEPTH];
	logic [CFG_BITS-1:0] cur_count = CFG_BITS'(CFG_RESET);
	int                  burst_left = 0;
	int                  idle_cycles = 0;
	rx_mode_t            rx_mode = RX_OPEN;
	int                  rx_left = 0;

	double_ended_nearest_neighbor_tour_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.row        (row),
		.col        (col),
		.distance   (distance),
		.final_entry(final_entry),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.city       (city),
		.tour_end   (tour_end),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: ready pattern switches at random between open, choppy and choked modes
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(5, 60);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
		if (arst_n && out_valid && out_ready)
			sb.check_city(city, tour_end);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[double_ended_nearest_neighbor_tour_core] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_entry(input logic [ROW_BITS-1:0] r, input logic [ROW_BITS-1:0] c,
			input logic [DIST_IN_BITS-1:0] d, input logic f);
		row <= r;
		col <= c;
		distance <= d;
		final_entry <= f;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_entry(r, c, d, f);
		written[{r, c}] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
	endtask

	// wait for the tour in flight to be delivered, then idle before going on
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
	endtask

	task automatic set_cities(input logic [CFG_BITS-1:0] v);
		settle();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		sb.set_count(v);
		cur_count = v;
		cfg_we <= 1'b0;
	endtask

	// one tour: every distance it can read is written first, plus rewrites and stray words
	task automatic run_tour(output int sent);
		pair_t                   plan [$];
		pair_t                   p;
		pair_t                   tmp;
		int                      n, r, c, j, k, sel;
		logic [DIST_IN_BITS-1:0] d;
		n = (cur_count == 0) ? 1 : (cur_count > MAX_CITIES) ? MAX_CITIES : int'(cur_count);
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				if (r != c && !written[r * MAX_CITIES + c]) begin
					p.r = ROW_BITS'(r);
					p.c = ROW_BITS'(c);
					plan.insert(plan.size(), p);
				end
		repeat ($urandom_range(0, 6)) begin
			p.r = ROW_BITS'($urandom_range(0, n - 1));
			p.c = ROW_BITS'($urandom_range(0, n - 1));
			plan.insert(plan.size(), p);
		end
		repeat ($urandom_range(0, 3)) begin
			p.r = ROW_BITS'($urandom_range(0, MAX_CITIES - 1));
			p.c = ROW_BITS'($urandom_range(0, MAX_CITIES - 1));
			plan.insert(plan.size(), p);
		end
		if (plan.size() == 0) begin
			p.r = ROW_BITS'($urandom_range(0, MAX_CITIES - 1));
			p.c = ROW_BITS'($urandom_range(0, MAX_CITIES - 1));
			plan.insert(plan.size(), p);
		end
		for (j = plan.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = plan[j];
			plan[j] = plan[k];
			plan[k] = tmp;
		end
		foreach (plan[i]) begin
			// small values give plenty of ties
			sel = $urandom_range(0, 9);
			if (sel < 4)
				d = DIST_IN_BITS'($urandom_range(0, 3));
			else if (sel == 4)
				d = '0;
			else if (sel == 5)
				d = '1;
			else
				d = DIST_IN_BITS'($urandom);
			send_entry(plan[i].r, plan[i].c, d, i == plan.size() - 1);
		end
		sent = plan.size();
	endtask

	initial begin
		int sent;
		int random_words;
		int sel;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		row <= '0;
		col <= '0;
		distance <= '0;
		final_entry <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		sb = new();
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single city, by count one and by count zero, then two cities
		set_cities(7'd1);
		send_entry(6'd63, 6'd63, 16'hFFFF, 1'b1);
		set_cities(7'd0);
		send_entry(6'd0, 6'd0, 16'h0000, 1'b1);
		set_cities(7'd2);
		send_entry(6'd0, 6'd1, 16'd7, 1'b0);
		send_entry(6'd1, 6'd0, 16'd7, 1'b1);
		// all distances equal: lowest index and the front end win
		set_cities(7'd3);
		send_entry(6'd0, 6'd1, 16'd5, 1'b0);
		send_entry(6'd0, 6'd2, 16'd5, 1'b0);
		send_entry(6'd1, 6'd0, 16'd5, 1'b0);
		send_entry(6'd1, 6'd2, 16'd5, 1'b0);
		send_entry(6'd2, 6'd0, 16'd5, 1'b0);
		send_entry(6'd2, 6'd1, 16'd5, 1'b1);
		// back end is nearer on the second step
		send_entry(6'd0, 6'd1, 16'd0, 1'b0);
		send_entry(6'd0, 6'd2, 16'd10, 1'b0);
		send_entry(6'd1, 6'd2, 16'hFFFF, 1'b1);
		// final mark on a word outside the cities in use
		send_entry(6'd40, 6'd50, 16'd123, 1'b1);

		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 1)) begin
				sel = $urandom_range(0, 9);
				if (sel < 2)
					set_cities(CFG_BITS'(sel));
				else if (sel < 6)
					set_cities(CFG_BITS'($urandom_range(2, 4)));
				else
					set_cities(CFG_BITS'($urandom_range(5, 10)));
			end
			run_tour(sent);
			random_words += sent;
		end

		settle();
		repeat (40)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[double_ended_nearest_neighbor_tour_core] OK");
		else
			$display("[double_ended_nearest_neighbor_tour_core] ERROR");
		$finish;
	end

endmodule
